@@ rtl/orl_pkg.sv @@
// Shared types and constants for the ordered request list core.
package orl_pkg;

	// Width of one stored request: button id, direction and level bytes.
	localparam int ENTRY_W = 24;

	// Data word returned by a pop or a peek on an empty list.
	localparam logic [ENTRY_W-1:0] EMPTY_WORD = 24'hFF_FFFF;

	// Command codes as they arrive on the command port.
	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_POP    = 2'd1,
		CMD_PEEK   = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_RD    = 5'b00010,
		ST_SHIFT = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_WRNEW = 5'b10000
	} state_t;

endpackage

@@ rtl/ordered_request_list_core.sv @@
// Ordered request list: positional insert, pop, peek and indexed read over one RAM.
//
// A request is taken at a rising edge where start is high and busy is low.
// Every request yields exactly one result, shown for one cycle with done high
// on ok, out_level, out_direction, out_button and count. The receiver cannot
// stall; a result must be taken in the cycle it is shown.
// The entries live in a single-port-write RAM with a registered read.
// Insert at the end, refused inserts, empty pop or peek and out-of-range reads
// finish straight from idle (done in the next cycle). Peek and an in-range read
// pass through the read state. Insert at position p with n entries stored moves
// n-p entries down one RAM slot a cycle, then writes the new entry. Pop with n
// entries moves n-1 entries up when n is above one, and skips the shift otherwise.
// busy is low in the cycle done is high, so a new request may be issued then.
// Reset empties the list at once; RAM contents are not cleared and entries at
// or beyond the count are never read.
module ordered_request_list_core #(
	parameter int DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] command,
	input  logic [4:0] position,
	input  logic [7:0] level,
	input  logic [7:0] direction,
	input  logic [7:0] button_id,
	output logic       done,
	output logic       ok,
	output logic [7:0] out_level,
	output logic [7:0] out_direction,
	output logic [7:0] out_button,
	output logic [4:0] count
);
	import orl_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > 5) ? CW : 5;

	// Entry storage, written once per cycle, read data registered.
	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [ENTRY_W-1:0] rd_data_s1;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;

	state_t             state_q, state_d;
	logic [CW-1:0]      count_q, count_d;
	cmd_t               cmd_q, cmd_d;
	logic [AW-1:0]      pos_q, pos_d;
	logic [ENTRY_W-1:0] data_q, data_d;
	logic [AW-1:0]      rd_q, rd_d;
	logic               pend_q, pend_d;
	logic [AW-1:0]      pend_addr_q, pend_addr_d;
	logic               ok_q, ok_d;
	logic [ENTRY_W-1:0] word_q, word_d;
	logic               done_q, done_d;

	logic [PW-1:0]      pos_x;
	logic [PW-1:0]      cnt_x;
	logic [AW-1:0]      last_idx;
	logic [ENTRY_W-1:0] new_word;

	assign pos_x    = PW'(position);
	assign cnt_x    = PW'(count_q);
	assign last_idx = AW'(count_q - 1'b1);
	assign new_word = {button_id, direction, level};

	// Sequencer: decodes a request, walks the shift through the RAM, loads the result.
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		cmd_d       = cmd_q;
		pos_d       = pos_q;
		data_d      = data_q;
		rd_d        = rd_q;
		pend_d      = 1'b0;
		pend_addr_d = pend_addr_q;
		ok_d        = ok_q;
		word_d      = word_q;
		done_d      = 1'b0;
		mem_we      = pend_q;
		mem_waddr   = pend_addr_q;
		mem_wdata   = rd_data_s1;
		mem_re      = 1'b0;
		mem_raddr   = rd_q;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd_d  = cmd_t'(command);
					pos_d  = pos_x[AW-1:0];
					data_d = new_word;
					unique case (cmd_t'(command))
						CMD_INSERT: begin
							if (pos_x > cnt_x || count_q == CW'(DEPTH)) begin
								ok_d   = 1'b0;
								word_d = '0;
								done_d = 1'b1;
							end else if (pos_x == cnt_x) begin
								mem_we    = 1'b1;
								mem_waddr = pos_x[AW-1:0];
								mem_wdata = new_word;
								count_d   = CW'(count_q + 1'b1);
								ok_d      = 1'b1;
								word_d    = '0;
								done_d    = 1'b1;
							end else begin
								rd_d    = last_idx;
								state_d = ST_SHIFT;
							end
						end
						CMD_POP, CMD_PEEK: begin
							if (count_q == '0) begin
								ok_d   = 1'b0;
								word_d = EMPTY_WORD;
								done_d = 1'b1;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = '0;
								state_d   = ST_RD;
							end
						end
						CMD_READ: begin
							if (pos_x < cnt_x) begin
								mem_re    = 1'b1;
								mem_raddr = pos_x[AW-1:0];
								state_d   = ST_RD;
							end else begin
								ok_d   = 1'b0;
								word_d = '0;
								done_d = 1'b1;
							end
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_RD: begin
				ok_d   = 1'b1;
				word_d = rd_data_s1;
				if (cmd_q == CMD_POP && count_q > CW'(1)) begin
					rd_d    = AW'(1);
					state_d = ST_SHIFT;
				end else begin
					if (cmd_q == CMD_POP) begin
						count_d = CW'(count_q - 1'b1);
					end
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SHIFT: begin
				// Read one entry, write it one slot over in the next cycle.
				mem_re    = 1'b1;
				mem_raddr = rd_q;
				pend_d    = 1'b1;
				if (cmd_q == CMD_INSERT) begin
					pend_addr_d = AW'(rd_q + 1'b1);
					if (rd_q == pos_q) begin
						state_d = ST_DRAIN;
					end else begin
						rd_d = AW'(rd_q - 1'b1);
					end
				end else begin
					pend_addr_d = AW'(rd_q - 1'b1);
					if (rd_q == last_idx) begin
						state_d = ST_DRAIN;
					end else begin
						rd_d = AW'(rd_q + 1'b1);
					end
				end
			end
			ST_DRAIN: begin
				// The last moved entry is written back here.
				if (cmd_q == CMD_INSERT) begin
					state_d = ST_WRNEW;
				end else begin
					count_d = CW'(count_q - 1'b1);
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_WRNEW: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = data_q;
				count_d   = CW'(count_q + 1'b1);
				ok_d      = 1'b1;
				word_d    = '0;
				done_d    = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_q  <= pend_d;
			done_q  <= done_d;
		end
	end

	// Request and result payload registers.
	always_ff @(posedge clk) begin
		cmd_q       <= cmd_d;
		pos_q       <= pos_d;
		data_q      <= data_d;
		rd_q        <= rd_d;
		pend_addr_q <= pend_addr_d;
		ok_q        <= ok_d;
		word_q      <= word_d;
	end

	// Entry RAM.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_s1 <= mem[mem_raddr];
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign ok            = ok_q;
	assign out_level     = word_q[7:0];
	assign out_direction = word_q[15:8];
	assign out_button    = word_q[23:16];
	assign count         = 5'(count_q);

`ifndef NO_ASSERTIONS
	// A result is only shown once the sequencer has returned to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE)
		else $error("result strobe outside idle");

	// The entry count never exceeds the storage depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	// Deferred write-backs only occur during the shift.
	a_pend_shift: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (state_q == ST_SHIFT || state_q == ST_DRAIN))
		else $error("pending write outside shift");

	// A peek leaves the count alone.
	a_peek_count: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command == CMD_PEEK) |=> $stable(count_q))
		else $error("peek changed the count");
`endif

endmodule

@@ sim/tb_ordered_request_list_core.sv @@
// Self-checking testbench for the ordered request list core: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_ordered_request_list_core;
	import orl_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int RANDOM_PER_PHASE = 500;

	// One request as presented on the command ports.
	typedef struct packed {
		cmd_t       cmd;
		logic [4:0] pos;
		logic [7:0] lvl;
		logic [7:0] dir;
		logic [7:0] btn;
	} request_t;

	// One result as shown with done.
	typedef struct packed {
		logic       ok;
		logic [7:0] lvl;
		logic [7:0] dir;
		logic [7:0] btn;
		logic [4:0] cnt;
	} reply_t;

	// A directed step; the reply is typed in only where typed is set.
	typedef struct packed {
		request_t rq;
		logic     typed;
		reply_t   want;
	} plan_row_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [1:0] command;
	logic [4:0] position;
	logic [7:0] level;
	logic [7:0] direction;
	logic [7:0] button_id;
	logic       done;
	logic       ok;
	logic [7:0] out_level;
	logic [7:0] out_direction;
	logic [7:0] out_button;
	logic [4:0] count;

	ordered_request_list_core #(.DEPTH(LIST_DEPTH)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.position      (position),
		.level         (level),
		.direction     (direction),
		.button_id     (button_id),
		.done          (done),
		.ok            (ok),
		.out_level     (out_level),
		.out_direction (out_direction),
		.out_button    (out_button),
		.count         (count)
	);

	// Shadow copy of the list contents and its fill level.
	logic [ENTRY_W-1:0] list_store [LIST_DEPTH];
	int                 list_count;

	// Results still owed by the block, oldest first.
	reply_t replies_due [$];
	int     mismatches;

	// Typed expectation for the request being presented, if any.
	logic   row_typed;
	reply_t row_reply;

	// Directed steps: empty-list cases, refused inserts, extremes, every command.
	plan_row_t plan [23] = '{
		'{'{CMD_PEEK,   5'd0,  8'h00, 8'h00, 8'h00}, 1'b1, '{1'b0, 8'hFF, 8'hFF, 8'hFF, 5'd0}},
		'{'{CMD_POP,    5'd0,  8'h00, 8'h00, 8'h00}, 1'b1, '{1'b0, 8'hFF, 8'hFF, 8'hFF, 5'd0}},
		'{'{CMD_READ,   5'd0,  8'h00, 8'h00, 8'h00}, 1'b1, '{1'b0, 8'h00, 8'h00, 8'h00, 5'd0}},
		'{'{CMD_INSERT, 5'd1,  8'h11, 8'h22, 8'h33}, 1'b1, '{1'b0, 8'h00, 8'h00, 8'h00, 5'd0}},
		'{'{CMD_INSERT, 5'd0,  8'hFF, 8'hFF, 8'hFF}, 1'b1, '{1'b1, 8'h00, 8'h00, 8'h00, 5'd1}},
		'{'{CMD_INSERT, 5'd1,  8'h00, 8'h00, 8'h00}, 1'b1, '{1'b1, 8'h00, 8'h00, 8'h00, 5'd2}},
		'{'{CMD_INSERT, 5'd0,  8'hA5, 8'h5A, 8'hC3}, 1'b1, '{1'b1, 8'h00, 8'h00, 8'h00, 5'd3}},
		'{'{CMD_INSERT, 5'd2,  8'h01, 8'h80, 8'h7E}, 1'b1, '{1'b1, 8'h00, 8'h00, 8'h00, 5'd4}},
		'{'{CMD_INSERT, 5'd16, 8'h44, 8'h55, 8'h66}, 1'b1, '{1'b0, 8'h00, 8'h00, 8'h00, 5'd4}},
		'{'{CMD_INSERT, 5'd5,  8'h77, 8'h88, 8'h99}, 1'b1, '{1'b0, 8'h00, 8'h00, 8'h00, 5'd4}},
		'{'{CMD_READ,   5'd0,  8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{'{CMD_READ,   5'd3,  8'hFF, 8'hFF, 8'hFF}, 1'b0, '0},
		'{'{CMD_READ,   5'd4,  8'h00, 8'h00, 8'h00}, 1'b1, '{1'b0, 8'h00, 8'h00, 8'h00, 5'd4}},
		'{'{CMD_READ,   5'd16, 8'h00, 8'h00, 8'h00}, 1'b1, '{1'b0, 8'h00, 8'h00, 8'h00, 5'd4}},
		'{'{CMD_PEEK,   5'd0,  8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{'{CMD_POP,    5'd0,  8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{'{CMD_POP,    5'd0,  8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{'{CMD_READ,   5'd1,  8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{'{CMD_POP,    5'd0,  8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{'{CMD_POP,    5'd0,  8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{'{CMD_POP,    5'd0,  8'h00, 8'h00, 8'h00}, 1'b1, '{1'b0, 8'hFF, 8'hFF, 8'hFF, 5'd0}},
		'{'{CMD_INSERT, 5'd0,  8'h5A, 8'hA5, 8'h3C}, 1'b1, '{1'b1, 8'h00, 8'h00, 8'h00, 5'd1}},
		'{'{CMD_READ,   5'd0,  8'h00, 8'h00, 8'h00}, 1'b0, '0}
	};

	// Free-running clock, 10 ns period.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one request to the shadow list and return the result it should give.
	function automatic reply_t apply_request(input request_t rq);
		reply_t             rp;
		logic [ENTRY_W-1:0] word;
		int                 i;
		rp = '0;
		word = '0;
		case (rq.cmd)
			CMD_INSERT: begin
				if (int'(rq.pos) <= list_count && list_count < LIST_DEPTH) begin
					for (i = list_count; i > int'(rq.pos); i--)
						list_store[i] = list_store[i-1];
					list_store[rq.pos] = {rq.btn, rq.dir, rq.lvl};
					list_count++;
					rp.ok = 1'b1;
				end
			end
			CMD_POP, CMD_PEEK: begin
				if (list_count == 0) begin
					word = EMPTY_WORD;
				end else begin
					word = list_store[0];
					rp.ok = 1'b1;
					if (rq.cmd == CMD_POP) begin
						for (i = 0; i + 1 < list_count; i++)
							list_store[i] = list_store[i+1];
						list_count--;
					end
				end
			end
			default: begin
				if (int'(rq.pos) < list_count) begin
					word = list_store[rq.pos];
					rp.ok = 1'b1;
				end
			end
		endcase
		rp.lvl = word[7:0];
		rp.dir = word[15:8];
		rp.btn = word[23:16];
		rp.cnt = list_count[4:0];
		return rp;
	endfunction

	// Compare one result field and count a mismatch.
	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Present a request after a random idle gap and hold it until accepted.
	task automatic send_request(input request_t rq, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start     <= 1'b1;
		command   <= rq.cmd;
		position  <= rq.pos;
		level     <= rq.lvl;
		direction <= rq.dir;
		button_id <= rq.btn;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	// Result checking and request acceptance, both sampled at the rising edge.
	reply_t got_reply;
	reply_t due_reply;
	reply_t predicted;
	always @(posedge clk) begin
		if (arst_n && done) begin
			got_reply = '{ok, out_level, out_direction, out_button, count};
			if (replies_due.size() == 0) begin
				$error("result shown with no request outstanding");
				mismatches++;
			end else begin
				due_reply = replies_due.pop_front();
				check_field("ok", due_reply.ok, got_reply.ok);
				check_field("out_level", due_reply.lvl, got_reply.lvl);
				check_field("out_direction", due_reply.dir, got_reply.dir);
				check_field("out_button", due_reply.btn, got_reply.btn);
				check_field("count", due_reply.cnt, got_reply.cnt);
			end
		end
		if (arst_n && start && !busy) begin
			predicted = apply_request('{cmd_t'(command), position, level, direction, button_id});
			replies_due.push_back(row_typed ? row_reply : predicted);
		end
	end

	// Stimulus: reset, directed table, then random traffic in three idling phases.
	request_t rq;
	int       idle_pct;
	int       mode;
	int       run_len;
	int       sent;
	int       pick;
	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		command    = CMD_INSERT;
		position   = '0;
		level      = '0;
		direction  = '0;
		button_id  = '0;
		list_count = 0;
		mismatches = 0;
		row_typed  = 1'b0;
		row_reply  = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[r]) begin
			row_typed = plan[r].typed;
			row_reply = plan[r].want;
			send_request(plan[r].rq, 17);
		end
		row_typed = 1'b0;

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 17 : (phase == 1) ? 88 : 0;
			sent = 0;
			while (sent < RANDOM_PER_PHASE) begin
				// Runs that fill the list, drain it, or mix commands freely.
				mode = $urandom_range(2);
				run_len = $urandom_range(30, 4);
				for (int k = 0; k < run_len; k++) begin
					pick = $urandom_range(99);
					case (mode)
						0: rq.cmd = (pick < 80) ? CMD_INSERT : cmd_t'($urandom_range(3));
						1: rq.cmd = (pick < 60) ? CMD_POP : (pick < 75) ? CMD_PEEK :
							(pick < 90) ? CMD_READ : CMD_INSERT;
						default: rq.cmd = cmd_t'($urandom_range(3));
					endcase
					// Mostly positions up to the fill level, sometimes any from 0 to 16.
					rq.pos = ($urandom_range(99) < 80) ? 5'($urandom_range(list_count)) :
						5'($urandom_range(16));
					rq.lvl = 8'($urandom);
					rq.dir = 8'($urandom);
					rq.btn = 8'($urandom);
					send_request(rq, idle_pct);
					sent++;
				end
			end
		end
		start <= 1'b0;

		// Drain outstanding results, then allow for the longest command.
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (25) @(posedge clk);
		if (mismatches == 0)
			$display("tb_ordered_request_list_core: PASS");
		else
			$display("tb_ordered_request_list_core: FAIL");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5_000_000;
		$display("tb_ordered_request_list_core: FAIL");
		$finish;
	end

endmodule
